>>> hw/rtl/sparse_triple_table_assert.svh
// assertion macros for the sparse triple table and its port checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef SPARSE_TRIPLE_TABLE_ASSERT_SVH
`define SPARSE_TRIPLE_TABLE_ASSERT_SVH

// condition implies consequence in the same cycle
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/stt_pkg.sv
// types and constants for the sparse triple table
// no dependencies; used by the top level and its checker
`default_nettype none

package stt_pkg;

  localparam int unsigned STT_MAX_ENTRIES = 64;
  localparam int unsigned STT_MAX_DIM     = 256;
  localparam int unsigned STT_CFG_W       = 9;
  localparam int unsigned STT_CFG_IDX_W   = 1;

  typedef enum logic [STT_CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } stt_cfg_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } stt_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZERO  = 2'd2,
    ST_FULL  = 2'd3
  } stt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } stt_state_e;

  typedef struct packed {
    stt_func_e          func;
    logic [7:0]         row_index;
    logic [7:0]         column_index;
    logic signed [31:0] entry_value;
  } stt_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    stt_status_e        status;
  } stt_out_t;

  typedef struct packed {
    logic [7:0]         row_index;
    logic [7:0]         column_index;
    logic signed [31:0] entry_value;
  } stt_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/sparse_triple_table.sv
// sparse triple table: coordinate-list store of nonzero matrix entries
// depends on stt_pkg
//
//   channel  | direction | payload    | handshake
//   in       | input     | stt_in_t   | in_valid_i / in_stall_o
//   out      | output    | stt_out_t  | out_valid_o / out_stall_i
//   cfg      | input     | 9-bit data | cfg_we_i, cfg_idx_i
//
// a write item, an out-of-range item and a read of an empty store go from acceptance
// straight to the finish state; a valid read first walks the triple memory until an
// entry matches or the last stored entry is checked, one read port access per entry,
// oldest first
// one item is in work at a time; in_stall_o is high from acceptance until
// the result moves into the output register
// the output register lets an item be accepted while the last result waits
// reset empties the store through the fill count, no clearing pass
`default_nettype none

module sparse_triple_table
  import stt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = STT_MAX_ENTRIES
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire stt_in_t                  in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output stt_out_t                      out_item_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [STT_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [STT_CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  stt_state_e state_q, state_d;

  logic [STT_CFG_W-1:0] row_count_q, column_count_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     cmp_q, cmp_d;
  logic [IDX_W-1:0]     rd_addr;
  stt_in_t              item_q, item_d;
  stt_out_t             res_q, res_d;
  stt_out_t             out_item_q, out_item_d;
  logic                 out_valid_q, out_valid_d;
  logic                 mem_we;
  stt_entry_t           rdata_q;

  stt_entry_t mem_q [MAX_ENTRIES];

  logic accept_in, idx_ok, is_write, val_zero, full, hit, last, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign idx_ok      = ({1'b0, in_item_i.row_index} < row_count_q) &&
                       ({1'b0, in_item_i.column_index} < column_count_q);
  assign is_write    = (in_item_i.func == FUNC_WRITE);
  assign val_zero    = (in_item_i.entry_value == 32'sd0);
  assign full        = (count_q == CNT_W'(MAX_ENTRIES));
  assign hit         = (rdata_q.row_index == item_q.row_index) &&
                       (rdata_q.column_index == item_q.column_index);
  assign last        = ((CNT_W'(cmp_q) + CNT_W'(1)) == count_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_addr     = (state_q == S_SCAN) ? (cmp_q + IDX_W'(1)) : '0;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          if (idx_ok && !is_write && (count_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    count_d     = count_q;
    cmp_d       = cmp_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          item_d           = in_item_i;
          cmp_d            = '0;
          res_d.read_value = 32'sd0;
          res_d.status     = ST_OK;
          if (!idx_ok) begin
            res_d.status = ST_RANGE;
          end else if (is_write) begin
            if (val_zero) begin
              res_d.status = ST_ZERO;
            end else if (full) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d.read_value = rdata_q.entry_value;
        end else begin
          cmp_d = cmp_q + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      row_count_q    <= STT_CFG_W'(STT_MAX_DIM);
      column_count_q <= STT_CFG_W'(STT_MAX_DIM);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
          CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    cmp_q      <= cmp_d;
    out_item_q <= out_item_d;
  end

  // triple memory: append at the fill count, one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= '{row_index:    in_item_i.row_index,
                                     column_index: in_item_i.column_index,
                                     entry_value:  in_item_i.entry_value};
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/stt_checker.sv
// port checker for the sparse triple table, bound to the top level
// depends on stt_pkg and sparse_triple_table_assert.svh
`default_nettype none

`include "sparse_triple_table_assert.svh"

module stt_checker
  import stt_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire stt_out_t out_item_o
);

  // a stalled result holds
  `STT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_item_o), "stalled result changed")

  // an error status never carries a value
  `STT_ASSERT_NOW(a_err_zero, out_valid_o && (out_item_o.status != ST_OK),
                  out_item_o.read_value == 32'sd0, "error result with nonzero value")

  // one item at a time: busy right after an accepted item
  `STT_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o,
                   "input not stalled after an accepted item")

endmodule

bind sparse_triple_table stt_checker u_stt_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for sparse_triple_table: directed and random items
// against a scoreboard that tracks the coordinate list and the row/column limits
// depends on stt_pkg and the sparse_triple_table rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 300;
  localparam int ROW_SETS [PHASES] = '{16, 1, 256, 9, 256, 200};
  localparam int COL_SETS [PHASES] = '{8, 256, 1, 9, 256, 77};

  // models the coordinate list and queues the result each accepted item should give
  class coord_scoreboard;
    logic [STT_CFG_W-1:0] row_limit;
    logic [STT_CFG_W-1:0] column_limit;
    stt_entry_t           held_triples[$];
    stt_out_t             pending_results[$];
    int                   mismatches;

    function new();
      row_limit = STT_CFG_W'(STT_MAX_DIM);
      column_limit = STT_CFG_W'(STT_MAX_DIM);
      mismatches = 0;
    endfunction

    function void set_register(stt_cfg_e idx, logic [STT_CFG_W-1:0] data);
      case (idx)
        CFG_ROW_COUNT: row_limit = data;
        CFG_COLUMN_COUNT: column_limit = data;
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task log_accepted_item(stt_in_t item);
      stt_out_t   want;
      stt_entry_t triple;
      bit         found;
      want.read_value = '0;
      want.status = ST_OK;
      found = 1'b0;
      if ({1'b0, item.row_index} >= row_limit || {1'b0, item.column_index} >= column_limit)
      begin
        want.status = ST_RANGE;
      end else if (item.func == FUNC_WRITE) begin
        if (item.entry_value == 0) begin
          want.status = ST_ZERO;
        end else if (held_triples.size() >= STT_MAX_ENTRIES) begin
          want.status = ST_FULL;
        end else begin
          triple.row_index = item.row_index;
          triple.column_index = item.column_index;
          triple.entry_value = item.entry_value;
          held_triples.push_back(triple);
        end
      end else begin
        // oldest match wins, later duplicates are shadowed
        foreach (held_triples[i]) begin
          if (!found && held_triples[i].row_index == item.row_index &&
              held_triples[i].column_index == item.column_index) begin
            found = 1'b1;
            want.read_value = held_triples[i].entry_value;
          end
        end
      end
      pending_results.push_back(want);
    endtask

    task check_result(stt_out_t got);
      stt_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d",
                                  got.read_value, got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value got %0d want %0d",
                                  got.read_value, want.read_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  stt_in_t                  in_item_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  stt_out_t                 out_item_o;
  logic                     cfg_we_i;
  logic [STT_CFG_IDX_W-1:0] cfg_idx_i;
  logic [STT_CFG_W-1:0]     cfg_data_i;

  coord_scoreboard sb;
  bit              send_calm;
  bit              recv_calm;
  bit              hold_request;

  sparse_triple_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic stt_in_t make_item(stt_func_e func, int row, int col, logic [31:0] value);
    stt_in_t item;
    item.func = func;
    item.row_index = 8'(row);
    item.column_index = 8'(col);
    item.entry_value = value;
    return item;
  endfunction

  // often one of the low indices 0 to 3 so reads find stored entries, plus the limit edges and any index
  function automatic logic [7:0] pick_index(logic [STT_CFG_W-1:0] limit);
    int idx;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: idx = $urandom_range(0, 3);
      4: idx = int'(limit) - 1;
      5: idx = int'(limit);
      default: idx = $urandom_range(0, 255);
    endcase
    if (idx > 255) idx = 255;
    return 8'(idx);
  endfunction

  function automatic stt_in_t random_item();
    stt_in_t     item;
    logic [31:0] value;
    case ($urandom_range(0, 9))
      0: value = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = 32'hffff_ffff;
          default: value = 32'h0000_0001;
        endcase
      end
      default: value = $urandom;
    endcase
    item = make_item(($urandom_range(0, 9) < 4) ? FUNC_WRITE : FUNC_READ,
                     pick_index(sb.row_limit), pick_index(sb.column_limit), value);
    return item;
  endfunction

  // called just after a rising edge, returns just after the accepting edge
  task automatic send_item(stt_in_t item, bit no_gap);
    int  gap;
    bit  taken;
    gap = no_gap ? 0 : draw_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) sb.log_accepted_item(item);
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(stt_cfg_e idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= STT_CFG_W'(data);
    @(posedge clk_i);
    sb.set_register(idx, STT_CFG_W'(data));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int count, int burst);
    for (int n = 0; n < count; n++) send_item(random_item(), n < burst);
    in_valid_i <= 1'b0;
    wait_idle();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int       n;
    bit       got;
    stt_out_t seen;
    out_stall_i = 1'b1;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = draw_gap(recv_calm);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      got = 1'b0;
      while (!got) begin
        @(negedge clk_i);
        got = out_valid_o;
        seen = out_item_o;
        @(posedge clk_i);
      end
      sb.check_result(seen);
    end
  end

  initial begin
    sb = new();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROW_COUNT;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: every index valid, corners and signed extremes
    send_item(make_item(FUNC_WRITE, 255, 255, 32'h7fff_ffff), 1'b0);
    send_item(make_item(FUNC_READ, 255, 255, 32'h0), 1'b0);
    send_item(make_item(FUNC_WRITE, 0, 0, 32'h8000_0000), 1'b0);
    send_item(make_item(FUNC_READ, 0, 0, 32'hffff_ffff), 1'b0);
    send_item(make_item(FUNC_READ, 17, 42, 32'h0), 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();

    write_register(CFG_ROW_COUNT, 4);
    write_register(CFG_COLUMN_COUNT, 3);
    // range errors on each side, range beats zero, zero write, shadowed duplicate
    send_item(make_item(FUNC_WRITE, 4, 0, 32'h5), 1'b0);
    send_item(make_item(FUNC_WRITE, 0, 3, 32'h5), 1'b0);
    send_item(make_item(FUNC_READ, 255, 255, 32'h0), 1'b0);
    send_item(make_item(FUNC_WRITE, 1, 2, 32'h0), 1'b0);
    send_item(make_item(FUNC_WRITE, 4, 3, 32'h0), 1'b0);
    send_item(make_item(FUNC_WRITE, 1, 2, 32'hffff_ffff), 1'b0);
    send_item(make_item(FUNC_WRITE, 1, 2, 32'd123), 1'b0);
    send_item(make_item(FUNC_READ, 1, 2, 32'h0), 1'b0);
    send_item(make_item(FUNC_READ, 3, 2, 32'h0), 1'b0);
    send_item(make_item(FUNC_WRITE, 3, 2, 32'h1), 1'b0);
    send_item(make_item(FUNC_READ, 3, 2, 32'h0), 1'b0);
    send_item(make_item(FUNC_READ, 0, 0, 32'h0), 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_ROW_COUNT, ROW_SETS[p]);
      write_register(CFG_COLUMN_COUNT, COL_SETS[p]);
      send_calm = (p == 3);
      recv_calm = (p == 4);
      // back-to-back items while the result side holds off fill the block
      if (p == 2) hold_request = 1'b1;
      run_phase(PHASE_ITEMS, (p == 2) ? 16 : 0);
    end

    repeat (STT_MAX_ENTRIES + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/sparse_triple_table.sv
hw/rtl/stt_checker.sv
tb/tb.sv
